// ===== sv/tcc_pkg.sv =====
package tcc_pkg;

  // Operation codes carried in the opcode field
  typedef enum logic [3:0] {
    OP_RESET    = 4'd0,
    OP_SAVE     = 4'd1,
    OP_RESTORE  = 4'd2,
    OP_SET_COL  = 4'd3,
    OP_SET_ROW  = 4'd4,
    OP_MOVE_COL = 4'd5,
    OP_MOVE_ROW = 4'd6,
    OP_TAB      = 4'd7,
    OP_INDEX    = 4'd8,
    OP_FORWARD  = 4'd9,
    OP_SET_ATTR = 4'd10
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_COLS   = 2'd0,
    REG_ROWS   = 2'd1,
    REG_DEF_FG = 2'd2,
    REG_DEF_BG = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SCROLL_NONE = 2'd0,
    SCROLL_UP   = 2'd1,
    SCROLL_DOWN = 2'd2
  } scroll_t;

  // Tab stops every TAB_STEP columns; must stay a power of two
  localparam int TAB_STEP = 8;

  localparam logic [7:0] COLS_RST   = 8'd80;
  localparam logic [7:0] ROWS_RST   = 8'd25;
  localparam logic [7:0] DEF_FG_RST = 8'd7;
  localparam logic [7:0] DEF_BG_RST = 8'd0;

  typedef struct packed {
    logic [15:0]       new_flags;
    logic [7:0]        new_background;
    logic [7:0]        new_foreground;
    logic signed [9:0] amount;
    logic [3:0]        opcode;
  } in_item_t;

  typedef struct packed {
    logic [15:0] flags;
    logic [7:0]  bg;
    logic [7:0]  fg;
    logic [7:0]  row;
    logic [7:0]  col;
  } cursor_t;

  typedef struct packed {
    logic [7:0] cols;
    logic [7:0] rows;
    logic [7:0] def_fg;
    logic [7:0] def_bg;
  } cfg_t;

  typedef struct packed {
    logic        clear_screen;
    logic [9:0]  scroll_lines;
    logic [1:0]  scroll_direction;
    logic [15:0] rendition_flags;
    logic [7:0]  background;
    logic [7:0]  foreground;
    logic [7:0]  cursor_row;
    logic [7:0]  cursor_column;
  } result_t;

  localparam int IN_W        = $bits(in_item_t);
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = $bits(result_t);
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

endpackage

// ===== sv/tcc_exec.sv =====
module tcc_exec (
  input  tcc_pkg::in_item_t item,
  input  tcc_pkg::cursor_t  cur,
  input  tcc_pkg::cursor_t  saved,
  input  tcc_pkg::cfg_t     cfg,
  output tcc_pkg::cursor_t  cur_nxt,
  output tcc_pkg::cursor_t  saved_nxt,
  output tcc_pkg::result_t  res
);

  // clamp to 0..w (one past the last column is legal)
  function automatic logic [7:0] clamp_col(logic signed [11:0] x, logic [7:0] w);
    logic signed [11:0] ws;
    ws = $signed({4'b0, w});
    if (x < 0)        clamp_col = 8'd0;
    else if (x >= ws) clamp_col = w;
    else              clamp_col = x[7:0];
  endfunction

  // clamp to 0..h-1, h nonzero
  function automatic logic [7:0] clamp_row(logic signed [11:0] x, logic [7:0] h);
    logic signed [11:0] hs;
    hs = $signed({4'b0, h});
    if (x < 0)        clamp_row = 8'd0;
    else if (x >= hs) clamp_row = h - 8'd1;
    else              clamp_row = x[7:0];
  endfunction

  logic [7:0]         h;
  logic signed [11:0] col_s, row_s, amt_s, cnt_s, y_idx, tab_x, y_hi;
  logic [7:0]         idx_row;
  logic [1:0]         idx_dir;
  logic [9:0]         idx_lines;
  logic               fwd_wrap;
  logic [7:0]         tab_base;

  always_comb begin
    h     = (cfg.rows == 8'd0) ? 8'd1 : cfg.rows;
    col_s = $signed({4'b0, cur.col});
    row_s = $signed({4'b0, cur.row});
    amt_s = {{2{item.amount[9]}}, item.amount};

    // index: forward uses a count of one line
    cnt_s = (tcc_pkg::op_t'(item.opcode) == tcc_pkg::OP_FORWARD) ? 12'sd1 : amt_s;
    y_idx = row_s + cnt_s;
    y_hi  = y_idx - ($signed({4'b0, h}) - 12'sd1);
    idx_row = clamp_row(y_idx, h);
    if (y_idx < 0) begin
      idx_dir   = tcc_pkg::SCROLL_DOWN;
      idx_lines = 10'(-y_idx);
    end else if (y_idx >= $signed({4'b0, h})) begin
      idx_dir   = tcc_pkg::SCROLL_UP;
      idx_lines = y_hi[9:0];
    end else begin
      idx_dir   = tcc_pkg::SCROLL_NONE;
      idx_lines = 10'd0;
    end

    tab_base = cur.col & ~8'(tcc_pkg::TAB_STEP - 1);
    tab_x    = $signed({4'b0, tab_base}) + 12'(tcc_pkg::TAB_STEP);
    fwd_wrap = ({1'b0, cur.col} + 9'd1) >= {1'b0, cfg.cols};

    cur_nxt   = cur;
    saved_nxt = saved;
    res.scroll_direction = tcc_pkg::SCROLL_NONE;
    res.scroll_lines     = 10'd0;
    res.clear_screen     = 1'b0;

    case (tcc_pkg::op_t'(item.opcode))
      tcc_pkg::OP_RESET: begin
        cur_nxt.col   = 8'd0;
        cur_nxt.row   = 8'd0;
        cur_nxt.fg    = cfg.def_fg;
        cur_nxt.bg    = cfg.def_bg;
        cur_nxt.flags = 16'd0;
        saved_nxt     = cur_nxt;
        res.clear_screen = 1'b1;
      end
      tcc_pkg::OP_SAVE:     saved_nxt   = cur;
      tcc_pkg::OP_RESTORE:  cur_nxt     = saved;
      tcc_pkg::OP_SET_COL:  cur_nxt.col = clamp_col(amt_s, cfg.cols);
      tcc_pkg::OP_SET_ROW:  cur_nxt.row = clamp_row(amt_s, h);
      tcc_pkg::OP_MOVE_COL: cur_nxt.col = clamp_col(col_s + amt_s, cfg.cols);
      tcc_pkg::OP_MOVE_ROW: cur_nxt.row = clamp_row(row_s + amt_s, h);
      tcc_pkg::OP_TAB:      cur_nxt.col = clamp_col(tab_x, cfg.cols);
      tcc_pkg::OP_INDEX: begin
        cur_nxt.row          = idx_row;
        res.scroll_direction = idx_dir;
        res.scroll_lines     = idx_lines;
      end
      tcc_pkg::OP_FORWARD: begin
        if (fwd_wrap) begin
          cur_nxt.col          = 8'd0;
          cur_nxt.row          = idx_row;
          res.scroll_direction = idx_dir;
          res.scroll_lines     = idx_lines;
        end else begin
          cur_nxt.col = cur.col + 8'd1;
        end
      end
      tcc_pkg::OP_SET_ATTR: begin
        cur_nxt.fg    = item.new_foreground;
        cur_nxt.bg    = item.new_background;
        cur_nxt.flags = item.new_flags;
      end
      default: ;
    endcase

    res.cursor_column   = cur_nxt.col;
    res.cursor_row      = cur_nxt.row;
    res.foreground      = cur_nxt.fg;
    res.background      = cur_nxt.bg;
    res.rendition_flags = cur_nxt.flags;
  end

endmodule

// ===== sv/terminal_cursor_controller.sv =====
// Terminal cursor controller: holds the cursor column/row, colors and
// rendition flags of a text terminal plus one saved copy, and applies one
// cursor operation per input item, returning exactly one result item with
// the state after the operation, any scroll request and the clear-screen
// flag. Throughput is one item per clock while out_tready is high. The
// result goes valid once its item has passed the input register and then
// the update logic into the state and result registers; a stall on the
// result side holds the item in the input register. The next-state logic
// feeds the state registers directly, so consecutive items see each other's
// effect with no gap. Write the screen size and default colors over the cfg
// port only while no item is in flight; the port is always ready.
module terminal_cursor_controller (
  input  logic                               clk,
  input  logic                               rst_n,

  // Operation input
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [3:0] opcode, [13:4] amount, [21:14] new_foreground,
  // [29:22] new_background, [45:30] new_flags, rest zero
  input  logic [tcc_pkg::IN_TDATA_W-1:0]     in_tdata,

  // Result output
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] cursor_column, [15:8] cursor_row, [23:16] foreground,
  // [31:24] background, [47:32] rendition_flags, [49:48] scroll_direction,
  // [59:50] scroll_lines, [60] clear_screen, rest zero
  output logic [tcc_pkg::OUT_TDATA_W-1:0]    out_tdata,

  // Configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [7:0]                         cfg_data
);

  tcc_pkg::in_item_t in_item_r;
  logic              in_vld_r;
  tcc_pkg::cursor_t  cur_r, saved_r, cur_nxt, saved_nxt;
  tcc_pkg::cfg_t     cfg_r;
  tcc_pkg::result_t  res_nxt, out_res_r;
  logic              out_vld_r;
  logic              advance;
  logic              in_acc;

  // The held item moves on whenever the result register is free or
  // being drained this cycle.
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(tcc_pkg::OUT_TDATA_W - tcc_pkg::OUT_W){1'b0}}, out_res_r};

  tcc_exec u_exec (
    .item      (in_item_r),
    .cur       (cur_r),
    .saved     (saved_r),
    .cfg       (cfg_r),
    .cur_nxt   (cur_nxt),
    .saved_nxt (saved_nxt),
    .res       (res_nxt)
  );

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= tcc_pkg::in_item_t'(in_tdata[tcc_pkg::IN_W-1:0]);
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  // Control, state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      cfg_r.cols    <= tcc_pkg::COLS_RST;
      cfg_r.rows    <= tcc_pkg::ROWS_RST;
      cfg_r.def_fg  <= tcc_pkg::DEF_FG_RST;
      cfg_r.def_bg  <= tcc_pkg::DEF_BG_RST;
      cur_r.col     <= 8'd0;
      cur_r.row     <= 8'd0;
      cur_r.fg      <= tcc_pkg::DEF_FG_RST;
      cur_r.bg      <= tcc_pkg::DEF_BG_RST;
      cur_r.flags   <= 16'd0;
      saved_r.col   <= 8'd0;
      saved_r.row   <= 8'd0;
      saved_r.fg    <= tcc_pkg::DEF_FG_RST;
      saved_r.bg    <= tcc_pkg::DEF_BG_RST;
      saved_r.flags <= 16'd0;
    end else begin
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end

      if (advance) begin
        out_vld_r <= 1'b1;
        cur_r     <= cur_nxt;
        saved_r   <= saved_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end

      if (cfg_valid) begin
        case (tcc_pkg::cfg_reg_t'(cfg_index))
          tcc_pkg::REG_COLS:   cfg_r.cols   <= cfg_data;
          tcc_pkg::REG_ROWS:   cfg_r.rows   <= cfg_data;
          tcc_pkg::REG_DEF_FG: cfg_r.def_fg <= cfg_data;
          tcc_pkg::REG_DEF_BG: cfg_r.def_bg <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Clear-screen comes only from reset, which never scrolls
  a_clear_no_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.clear_screen |-> out_res_r.scroll_direction == tcc_pkg::SCROLL_NONE)
    else $error("clear_screen with scroll request");

  // No scroll means no line count
  a_lines_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.scroll_direction == tcc_pkg::SCROLL_NONE
      |-> out_res_r.scroll_lines == 10'd0)
    else $error("scroll_lines nonzero without scroll");

  // Cursor state only changes when an item moves into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(cur_r) && $stable(saved_r))
    else $error("cursor state changed without an item");

  // Every processed item lands in the result register
  a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("processed item produced no result");

endmodule

// ===== dv/tcc_tb_pkg.sv =====
package tcc_tb_pkg;
  import tcc_pkg::*;

  // Tracks the cursor state alongside the block and checks every result item
  // against the state it predicts.
  class cursor_tracker;
    logic [7:0]  cols, rows, def_fg, def_bg;
    logic [7:0]  col, row, fg, bg;
    logic [15:0] flags;
    logic [7:0]  saved_col, saved_row, saved_fg, saved_bg;
    logic [15:0] saved_flags;

    result_t pending_reports[$];
    int ops, reg_writes, reports, mismatches;
    int scroll_ups, scroll_downs, clears;

    function new();
      cols   = COLS_RST;
      rows   = ROWS_RST;
      def_fg = DEF_FG_RST;
      def_bg = DEF_BG_RST;
      col    = '0;
      row    = '0;
      fg     = def_fg;
      bg     = def_bg;
      flags  = '0;
      snapshot();
    endfunction

    function void snapshot();
      saved_col   = col;
      saved_row   = row;
      saved_fg    = fg;
      saved_bg    = bg;
      saved_flags = flags;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [7:0] val);
      reg_writes++;
      case (idx)
        REG_COLS:   cols   = val;
        REG_ROWS:   rows   = val;
        REG_DEF_FG: def_fg = val;
        REG_DEF_BG: def_bg = val;
        default: ;
      endcase
    endfunction

    // zero rows acts as a one-row screen
    function int row_span();
      return (rows == 8'd0) ? 1 : int'(rows);
    endfunction

    // column may sit one past the last cell
    function void place_col(int x);
      col = (x < 0) ? 8'd0 : ((x >= int'(cols)) ? cols : 8'(x));
    endfunction

    function void place_row(int y);
      int h;
      h = row_span();
      row = (y < 0) ? 8'd0 : ((y >= h) ? 8'(h - 1) : 8'(y));
    endfunction

    function void line_index(input int count, output scroll_t dir, output int lines);
      int y, h;
      y = int'(row) + count;
      h = row_span();
      place_row(y);
      dir   = SCROLL_NONE;
      lines = 0;
      if (y < 0) begin
        dir   = SCROLL_DOWN;
        lines = -y;
      end else if (y >= h) begin
        dir   = SCROLL_UP;
        lines = y - (h - 1);
      end
    endfunction

    function result_t apply_op(in_item_t it);
      result_t r;
      int      amt;
      scroll_t dir;
      int      lines;
      logic    clr;
      amt   = $signed(it.amount);
      dir   = SCROLL_NONE;
      lines = 0;
      clr   = 1'b0;
      case (it.opcode)
        OP_RESET: begin
          col   = '0;
          row   = '0;
          fg    = def_fg;
          bg    = def_bg;
          flags = '0;
          snapshot();
          clr   = 1'b1;
        end
        OP_SAVE: snapshot();
        OP_RESTORE: begin
          col   = saved_col;
          row   = saved_row;
          fg    = saved_fg;
          bg    = saved_bg;
          flags = saved_flags;
        end
        OP_SET_COL:  place_col(amt);
        OP_SET_ROW:  place_row(amt);
        OP_MOVE_COL: place_col(int'(col) + amt);
        OP_MOVE_ROW: place_row(int'(row) + amt);
        OP_TAB:      place_col((int'(col) / TAB_STEP + 1) * TAB_STEP);
        OP_INDEX:    line_index(amt, dir, lines);
        OP_FORWARD: begin
          if (int'(col) + 1 < int'(cols)) begin
            col = col + 8'd1;
          end else begin
            place_col(0);
            line_index(1, dir, lines);
          end
        end
        OP_SET_ATTR: begin
          fg    = it.new_foreground;
          bg    = it.new_background;
          flags = it.new_flags;
        end
        default: ;
      endcase
      r.cursor_column    = col;
      r.cursor_row       = row;
      r.foreground       = fg;
      r.background       = bg;
      r.rendition_flags  = flags;
      r.scroll_direction = dir;
      r.scroll_lines     = 10'(lines);
      r.clear_screen     = clr;
      return r;
    endfunction

    function void note_op(in_item_t it);
      ops++;
      pending_reports.push_back(apply_op(it));
    endfunction

    function void complain(string why, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s", why);
        $display("  expected col %0d row %0d fg %0d bg %0d flags %h scroll %0d/%0d clear %0b",
                 want.cursor_column, want.cursor_row, want.foreground, want.background,
                 want.rendition_flags, want.scroll_direction, want.scroll_lines,
                 want.clear_screen);
        $display("  actual   col %0d row %0d fg %0d bg %0d flags %h scroll %0d/%0d clear %0b",
                 got.cursor_column, got.cursor_row, got.foreground, got.background,
                 got.rendition_flags, got.scroll_direction, got.scroll_lines,
                 got.clear_screen);
      end
    endfunction

    function void check_report(result_t got);
      result_t want;
      bit      bad;
      reports++;
      if (got.scroll_direction == SCROLL_UP)   scroll_ups++;
      if (got.scroll_direction == SCROLL_DOWN) scroll_downs++;
      if (got.clear_screen)                    clears++;
      if (pending_reports.size() == 0) begin
        want = '0;
        complain("result item with no operation outstanding", want, got);
        return;
      end
      want = pending_reports.pop_front();
      bad  = (got.cursor_column    !== want.cursor_column)
          || (got.cursor_row       !== want.cursor_row)
          || (got.foreground       !== want.foreground)
          || (got.background       !== want.background)
          || (got.rendition_flags  !== want.rendition_flags)
          || (got.scroll_direction !== want.scroll_direction)
          || (got.scroll_lines     !== want.scroll_lines)
          || (got.clear_screen     !== want.clear_screen);
      if (bad) complain($sformatf("result %0d mismatch", reports), want, got);
    endfunction
  endclass

endpackage

// ===== dv/terminal_cursor_controller_tb.sv =====
module terminal_cursor_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;
  import tcc_tb_pkg::*;

  localparam int LIMIT_CYCLES  = 300000;
  localparam int HOLD_CYCLES   = 64;   // long receiver hold-off, fills the pipe
  localparam int SETTLE_CYCLES = 6;    // margin after the last result
  localparam int PHASES        = 6;
  localparam int OPS_PER_PHASE = 115;

  // opcode values with no operation behind them
  localparam logic [3:0] OP_SPARE_FIRST = 4'd11;
  localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

  // per-phase idle percentages: none, sender, receiver, both, none + hold-off, both
  int gap_tbl   [PHASES] = '{0, 69, 0, 10, 0, 10};
  int stall_tbl [PHASES] = '{0, 0, 69, 10, 0, 10};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = '0;
  logic [7:0]             cfg_data = '0;

  cursor_tracker tracker;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  terminal_cursor_controller u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: anything past the limit means a hang or a lost item.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               tracker.pending_reports.size());
      $display("terminal_cursor_controller_tb: errors");
      $finish;
    end
  end

  // Result side. A requested hold-off is counted down here; otherwise
  // tready drops at random with the current phase's stall rate.
  always @(posedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitors: every handshake is seen here, pre-edge values only.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        tracker.note_op(in_item_t'(in_tdata[IN_W-1:0]));
      if (out_tvalid && out_tready)
        tracker.check_report(result_t'(out_tdata[OUT_W-1:0]));
      if (cfg_valid && cfg_ready)
        tracker.write_reg(cfg_reg_t'(cfg_index), cfg_data);
    end
  end

  // Offer one item, with random idle cycles ahead of it; returns on the
  // edge where it was taken, leaving tvalid high for a back-to-back item.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - IN_W){1'b0}}, it};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending and wait for every outstanding result, plus pipeline slack.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t op_item(input logic [3:0] op, input int amt,
                                       input logic [7:0] fgc = 8'd0,
                                       input logic [7:0] bgc = 8'd0,
                                       input logic [15:0] fl = 16'd0);
    in_item_t it;
    it.opcode         = op;
    it.amount         = 10'(amt);
    it.new_foreground = fgc;
    it.new_background = bgc;
    it.new_flags      = fl;
    return it;
  endfunction

  // Random operation. Amounts mostly land near the current screen size so
  // clamps, wraps and scrolls happen often; a quarter span the full range.
  function automatic in_item_t random_op();
    in_item_t it;
    int pick, span, amt;
    it.new_foreground = 8'($urandom);
    it.new_background = 8'($urandom);
    it.new_flags      = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 3)       it.opcode = OP_RESET;
    else if (pick < 10) it.opcode = OP_SAVE;
    else if (pick < 17) it.opcode = OP_RESTORE;
    else if (pick < 27) it.opcode = OP_SET_COL;
    else if (pick < 35) it.opcode = OP_SET_ROW;
    else if (pick < 47) it.opcode = OP_MOVE_COL;
    else if (pick < 57) it.opcode = OP_MOVE_ROW;
    else if (pick < 64) it.opcode = OP_TAB;
    else if (pick < 76) it.opcode = OP_INDEX;
    else if (pick < 90) it.opcode = OP_FORWARD;
    else if (pick < 96) it.opcode = OP_SET_ATTR;
    else                it.opcode = 4'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    if ($urandom_range(3) == 0) begin
      amt = int'($urandom_range(0, 1023)) - 512;
    end else begin
      if (it.opcode == OP_SET_COL || it.opcode == OP_MOVE_COL)
        span = int'(tracker.cols) + 2;
      else
        span = int'(tracker.rows) + 2;
      if (it.opcode == OP_SET_COL || it.opcode == OP_SET_ROW)
        amt = int'($urandom_range(0, span));
      else
        amt = int'($urandom_range(0, 2 * span)) - span;
    end
    it.amount = 10'(amt);
    return it;
  endfunction

  // Directed corners on the 80x25 reset screen.
  task automatic run_edge_cases();
    send_item(op_item(OP_SET_ATTR, 0, 8'hFF, 8'hFF, 16'hFFFF));
    send_item(op_item(OP_SAVE, 0));
    send_item(op_item(OP_SET_ATTR, 0));
    send_item(op_item(OP_SET_COL, 511));      // clamps to one past last column
    send_item(op_item(OP_SET_COL, -512));
    send_item(op_item(OP_SET_ROW, 511));      // clamps to last row
    send_item(op_item(OP_SET_ROW, -512));
    send_item(op_item(OP_MOVE_COL, 511));
    send_item(op_item(OP_MOVE_COL, -512));
    send_item(op_item(OP_MOVE_ROW, 511));
    send_item(op_item(OP_MOVE_ROW, -512));
    send_item(op_item(OP_INDEX, 511));        // large scroll up
    send_item(op_item(OP_INDEX, -512));       // large scroll down
    send_item(op_item(OP_INDEX, 0));
    send_item(op_item(OP_SET_COL, 77));
    send_item(op_item(OP_TAB, 0));            // tab stop past the edge clamps
    send_item(op_item(OP_TAB, 0));            // already at the edge
    send_item(op_item(OP_SET_ROW, 24));
    send_item(op_item(OP_SET_COL, 79));
    send_item(op_item(OP_FORWARD, 0));        // wrap on the bottom row: scroll one
    send_item(op_item(OP_FORWARD, 0));
    send_item(op_item(OP_RESTORE, 0));
    send_item(op_item(OP_SPARE_FIRST, 0));
    send_item(op_item(OP_SPARE_LAST, -1, 8'hFF, 8'hFF, 16'hFFFF));
    send_item(op_item(OP_RESET, 0));
  endtask

  initial begin
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      gap_pct   = gap_tbl[p];
      stall_pct = stall_tbl[p];
      // Screen setup, only with nothing in flight. Phase 0 keeps reset values.
      case (p)
        1: begin
          write_reg(REG_COLS, 8'd255);
          write_reg(REG_ROWS, 8'd255);
          write_reg(REG_DEF_FG, 8'd255);
          write_reg(REG_DEF_BG, 8'd255);
        end
        2: begin
          write_reg(REG_COLS, 8'd1);
          write_reg(REG_ROWS, 8'd1);
          write_reg(REG_DEF_FG, 8'd0);
          write_reg(REG_DEF_BG, 8'd0);
        end
        3: begin
          // zero-size screen: column pinned, rows act as one
          write_reg(REG_COLS, 8'd0);
          write_reg(REG_ROWS, 8'd0);
          write_reg(REG_DEF_FG, 8'hA5);
          write_reg(REG_DEF_BG, 8'h5A);
        end
        4: begin
          write_reg(REG_COLS, 8'd40);
          write_reg(REG_ROWS, 8'd12);
          write_reg(REG_DEF_FG, 8'($urandom));
          write_reg(REG_DEF_BG, 8'($urandom));
        end
        5: begin
          write_reg(REG_COLS, 8'($urandom_range(1, 255)));
          write_reg(REG_ROWS, 8'($urandom_range(1, 255)));
          write_reg(REG_DEF_FG, 8'($urandom));
          write_reg(REG_DEF_BG, 8'($urandom));
        end
        default: ;
      endcase

      if (p == 0) run_edge_cases();
      // back-pressure: receiver holds off while the sender keeps pushing
      if (p == 4) hold_asked = hold_asked + 1;

      repeat (OPS_PER_PHASE) send_item(random_op());
      wait_drained();
    end

    $display("ran %0d operations over %0d screen setups (%0d register writes, %0d results)",
             tracker.ops, PHASES, tracker.reg_writes, tracker.reports);
    $display("saw %0d scroll-ups, %0d scroll-downs, %0d screen clears; %0d mismatches",
             tracker.scroll_ups, tracker.scroll_downs, tracker.clears, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0) begin
      $display("terminal_cursor_controller_tb: clean");
    end else begin
      $display("terminal_cursor_controller_tb: errors");
    end
    $finish;
  end

endmodule

// ===== terminal_cursor_controller.f =====
sv/tcc_pkg.sv
sv/tcc_exec.sv
sv/terminal_cursor_controller.sv
dv/tcc_tb_pkg.sv
dv/terminal_cursor_controller_tb.sv
